### rtl/tdpc_pkg.sv
// ----------------------------------------------------------------------------
// Track/detection pair cost package
// Shared constants, command and register codes, and the arcsine table builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tdpc_pkg;

  // Default geometry of the block
  localparam int COORD_BITS_DEF  = 13;
  localparam int ASIN_DEPTH_DEF  = 1024;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_DATA_W-1:0] IOU_THRESHOLD_RST = 17'd19661;
  localparam logic [CFG_DATA_W-1:0] ANGLE_WEIGHT_RST  = 17'd13107;

  // Result channel: score (19) and IoU (17), padded to whole bytes
  localparam int SCORE_W    = 19;
  localparam int IOU_W      = 17;
  localparam int OUT_DATA_W = 40;

  // Arcsine table entries, Q0.16 of asin(x)/pi, at most 32768
  localparam int ASIN_ENTRY_W = 16;

  // pi in Q30
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_SCORE = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IOU_THRESHOLD = 1'b0,
    REG_ANGLE_WEIGHT  = 1'b1
  } reg_idx_e;

  // sin(m * pi / 131072) in Q30 by a Taylor series up to the 13th power.
  function automatic logic [63:0] sin_q30(input logic [63:0] m);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x    = (m * PI_Q30) >> 17;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int n = 1; n <= 6; n++) begin
      term = (term * x2) >> 30;
      term = term / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    return (sum < 0) ? 64'd0 : unsigned'(sum);
  endfunction

  // Table entry k: count of t in [0, 32767] with sin((2t+1)pi/131072) < k/(depth-1).
  // Evaluated at elaboration only.
  function automatic logic [ASIN_ENTRY_W-1:0] asin_entry(input int k, input int depth);
    logic [63:0] d;
    logic [63:0] target;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    d      = 64'(depth - 1);
    target = 64'(k) << 30;
    lo     = 32'd0;
    hi     = 32'd32768;
    for (int it = 0; it < 17; it++) begin
      if (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (sin_q30(2 * 64'(mid) + 64'd1) * d < target) begin
          lo = mid + 32'd1;
        end else begin
          hi = mid;
        end
      end
    end
    return lo[ASIN_ENTRY_W-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/tdpc_div.sv
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage. The quotient must
// fit in QW bits (num < den << QW); the remainder is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tdpc_div #(
  parameter int NW = 40,
  parameter int DW = 25,
  parameter int QW = 17
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int B = QW - 1 - i;

    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [CW-1:0] shifted;
    logic [NW-1:0] rem_d;
    logic [QW-1:0] quo_d;

    if (i == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    // Try to take the shifted divisor off the partial remainder.
    always_comb begin
      shifted = CW'(den_in) << B;
      rem_d   = rem_in;
      quo_d   = quo_in;
      if (CW'(rem_in) >= shifted) begin
        rem_d    = NW'(CW'(rem_in) - shifted);
        quo_d[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= rem_d;
        den_q[i] <= den_in;
        quo_q[i] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

`default_nettype wire

### rtl/tdpc_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor of the square root of a VW-bit radicand, one root bit per register
// stage, VW/2 stages in all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tdpc_isqrt #(
  parameter int VW = 46
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [VW-1:0]     rad_i,
  output logic [VW/2-1:0]   root_o
);

  localparam int S = VW / 2;

  logic [VW-1:0] v_q [S];
  logic [VW-1:0] r_q [S];

  for (genvar k = 0; k < S; k++) begin : g_stage
    localparam logic [VW-1:0] BIT = {{(VW-1){1'b0}}, 1'b1} << (VW - 2 - 2 * k);

    logic [VW-1:0] v_in;
    logic [VW-1:0] r_in;
    logic [VW:0]   trial;
    logic [VW-1:0] v_d;
    logic [VW-1:0] r_d;

    if (k == 0) begin : g_first
      assign v_in = rad_i;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign r_in = r_q[k-1];
    end

    // Accept the next root bit when the remainder allows it.
    always_comb begin
      trial = {1'b0, r_in} + {1'b0, BIT};
      v_d   = v_in;
      r_d   = r_in >> 1;
      if ({1'b0, v_in} >= trial) begin
        v_d = v_in - trial[VW-1:0];
        r_d = (r_in >> 1) + BIT;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k] <= v_d;
        r_q[k] <= r_d;
      end
    end
  end

  assign root_o = r_q[S-1][S-1:0];

endmodule

`default_nettype wire

### rtl/track_detection_pair_cost_unit.sv
// ----------------------------------------------------------------------------
// Track/detection pair cost unit
// Scores a detection against a loaded track: gated IoU plus a weighted
// direction-consistency term, as a fully pipelined datapath.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one request per transfer. With tuser low it
//   loads the track registers (predicted box, observed centre, inertia) and
//   produces no result. With tuser high it scores the detection box and
//   confidence against the current track and produces one result: gated
//   flag on tuser, score and IoU on tdata.
//   Throughput is one request per cycle while the receiver takes results.
//   A score request passes through the square-root and cosine divider
//   pipelines, one bit per stage. A load takes effect for the very next
//   request.
//   When the receiver stalls with a result pending, the whole pipeline holds
//   and s_axis_tready drops; nothing is lost or repeated.
//   Reset clears the track to all zero, restores the register defaults and
//   empties the pipeline. Configuration writes take effect at once. The user
//   makes them while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module track_detection_pair_cost_unit #(
  parameter int COORD_BITS       = tdpc_pkg::COORD_BITS_DEF,
  parameter int ASIN_TABLE_DEPTH = tdpc_pkg::ASIN_DEPTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write port
  input  logic                                   cfg_we_i,
  input  logic [tdpc_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [tdpc_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  // Request stream
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata, low to high: box_left, box_top, box_width, box_height,
  // observed_center_x, observed_center_y, velocity_x, velocity_y, confidence
  input  logic [((4*COORD_BITS+81)/8)*8-1:0]     s_axis_tdata,
  // tuser: command
  input  logic                                   s_axis_tuser,
  // Result stream
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // tdata, low to high: score, iou_value
  output logic [tdpc_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  // tuser: gated
  output logic                                   m_axis_tuser
);

  import tdpc_pkg::*;

  localparam int CB      = COORD_BITS;
  localparam int XW      = ((CB > 13) ? CB : 13) + 1;  // box edge width
  localparam int SW      = XW + 1;                      // centre offset width
  localparam int N2W     = 2 * SW;                      // squared length
  localparam int VW      = N2W + 16;                    // radicand width
  localparam int RW      = VW / 2;                      // root width
  localparam int PXW     = 16 + SW;                     // inertia product
  localparam int DOTW    = SW + 17;                     // dot product
  localparam int MW      = SW + 16;                     // dot magnitude
  localparam int CMPW    = ((MW + 8) > (RW + 15)) ? (MW + 8) : (RW + 15);
  localparam int IW      = $clog2(ASIN_TABLE_DEPTH);
  localparam int IPW     = 15 + IW;
  localparam int IOU_QW  = 17;
  localparam int COS_QW  = 15;
  localparam int IOU_DLY = RW - IOU_QW;
  localparam int NSTAGE  = RW + 24;
  localparam int AREA_W  = 24;
  localparam int UNI_W   = 25;
  localparam int P1W     = 33;
  localparam int PW      = 49;

  localparam int OFF_TOP  = CB;
  localparam int OFF_W    = 2 * CB;
  localparam int OFF_H    = 2 * CB + 12;
  localparam int OFF_CX   = 2 * CB + 24;
  localparam int OFF_CY   = 3 * CB + 25;
  localparam int OFF_IX   = 4 * CB + 26;
  localparam int OFF_IY   = 4 * CB + 42;
  localparam int OFF_CONF = 4 * CB + 58;

  localparam logic [14:0] COS_ONE = 15'd16384;

  typedef struct packed {
    logic [MW-1:0]    mag;
    logic             neg;
    logic             dir_ok;
    logic [P1W-1:0]   p1;
    logic             disj;
    logic             zero_uni;
    logic             ovf;
    logic [IOU_W-1:0] iou;
  } sb_t;

  // --------------------------------------------------------------------------
  // Request fields
  // --------------------------------------------------------------------------
  logic signed [CB-1:0] in_left;
  logic signed [CB-1:0] in_top;
  logic [11:0]          in_w;
  logic [11:0]          in_h;
  logic signed [CB:0]   in_cx;
  logic signed [CB:0]   in_cy;
  logic signed [15:0]   in_ix;
  logic signed [15:0]   in_iy;
  logic [15:0]          in_conf;

  assign in_left = s_axis_tdata[CB-1:0];
  assign in_top  = s_axis_tdata[OFF_TOP +: CB];
  assign in_w    = s_axis_tdata[OFF_W +: 12];
  assign in_h    = s_axis_tdata[OFF_H +: 12];
  assign in_cx   = s_axis_tdata[OFF_CX +: CB+1];
  assign in_cy   = s_axis_tdata[OFF_CY +: CB+1];
  assign in_ix   = s_axis_tdata[OFF_IX +: 16];
  assign in_iy   = s_axis_tdata[OFF_IY +: 16];
  assign in_conf = s_axis_tdata[OFF_CONF +: 16];

  // --------------------------------------------------------------------------
  // Handshake: the whole pipeline advances unless a result waits untaken.
  // --------------------------------------------------------------------------
  logic en;
  logic accept;
  logic accept_score;
  logic accept_load;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && en;
  assign accept_score  = accept && (s_axis_tuser == CMD_SCORE);
  assign accept_load   = accept && (s_axis_tuser == CMD_LOAD);

  logic [NSTAGE-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NSTAGE-2:0], accept_score};
    end
  end

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CFG_DATA_W-1:0] iou_thr_q;
  logic [CFG_DATA_W-1:0] angle_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iou_thr_q <= IOU_THRESHOLD_RST;
      angle_w_q <= ANGLE_WEIGHT_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_IOU_THRESHOLD: iou_thr_q <= cfg_data_i;
        REG_ANGLE_WEIGHT:  angle_w_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Track registers, written by a load request
  // --------------------------------------------------------------------------
  logic signed [CB-1:0] trk_left_q;
  logic signed [CB-1:0] trk_top_q;
  logic signed [XW-1:0] trk_right_q;
  logic signed [XW-1:0] trk_bottom_q;
  logic [AREA_W-1:0]    trk_area_q;
  logic signed [CB:0]   trk_cx_q;
  logic signed [CB:0]   trk_cy_q;
  logic signed [15:0]   trk_ix_q;
  logic signed [15:0]   trk_iy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_left_q   <= '0;
      trk_top_q    <= '0;
      trk_right_q  <= '0;
      trk_bottom_q <= '0;
      trk_area_q   <= '0;
      trk_cx_q     <= '0;
      trk_cy_q     <= '0;
      trk_ix_q     <= '0;
      trk_iy_q     <= '0;
    end else if (accept_load) begin
      trk_left_q   <= in_left;
      trk_top_q    <= in_top;
      trk_right_q  <= XW'(in_left) + XW'(in_w);
      trk_bottom_q <= XW'(in_top) + XW'(in_h);
      trk_area_q   <= AREA_W'(in_w * in_h);
      trk_cx_q     <= in_cx;
      trk_cy_q     <= in_cy;
      trk_ix_q     <= in_ix;
      trk_iy_q     <= in_iy;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: overlap edges and centre offset
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] det_l;
  logic signed [XW-1:0] det_t;
  logic signed [XW-1:0] det_r;
  logic signed [XW-1:0] det_b;
  logic signed [XW-1:0] trk_l;
  logic signed [XW-1:0] trk_t;

  assign det_l = XW'(in_left);
  assign det_t = XW'(in_top);
  assign det_r = XW'(in_left) + XW'(in_w);
  assign det_b = XW'(in_top) + XW'(in_h);
  assign trk_l = XW'(trk_left_q);
  assign trk_t = XW'(trk_top_q);

  logic signed [XW-1:0] s1_il_q, s1_ir_q, s1_it_q, s1_ib_q;
  logic signed [SW-1:0] s1_sx_q, s1_sy_q;
  logic [11:0]          s1_w_q, s1_h_q;
  logic [15:0]          s1_conf_q;
  logic signed [15:0]   s1_ix_q, s1_iy_q;
  logic                 s1_inr_nz_q;
  logic [AREA_W-1:0]    s1_tarea_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_il_q     <= (trk_l > det_l) ? trk_l : det_l;
      s1_ir_q     <= (trk_right_q < det_r) ? trk_right_q : det_r;
      s1_it_q     <= (trk_t > det_t) ? trk_t : det_t;
      s1_ib_q     <= (trk_bottom_q < det_b) ? trk_bottom_q : det_b;
      s1_sx_q     <= SW'(in_left) + SW'(in_w[11:1]) - SW'(trk_cx_q);
      s1_sy_q     <= SW'(in_top) + SW'(in_h[11:1]) - SW'(trk_cy_q);
      s1_w_q      <= in_w;
      s1_h_q      <= in_h;
      s1_conf_q   <= in_conf;
      s1_ix_q     <= trk_ix_q;
      s1_iy_q     <= trk_iy_q;
      s1_inr_nz_q <= (trk_ix_q != '0) || (trk_iy_q != '0);
      s1_tarea_q  <= trk_area_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: overlap extent and the products
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] ov_w;
  logic signed [XW-1:0] ov_h;

  assign ov_w = s1_ir_q - s1_il_q;
  assign ov_h = s1_ib_q - s1_it_q;

  logic                  s2_disj_q;
  logic [11:0]           s2_dx_q, s2_dy_q;
  logic [AREA_W-1:0]     s2_darea_q, s2_tarea_q;
  logic [N2W-1:0]        s2_sxx_q, s2_syy_q;
  logic signed [PXW-1:0] s2_pxx_q, s2_pyy_q;
  logic [P1W-1:0]        s2_p1_q;
  logic                  s2_inr_nz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_disj_q   <= (s1_il_q > s1_ir_q) || (s1_it_q > s1_ib_q);
      s2_dx_q     <= ov_w[11:0];
      s2_dy_q     <= ov_h[11:0];
      s2_darea_q  <= AREA_W'(s1_w_q * s1_h_q);
      s2_tarea_q  <= s1_tarea_q;
      s2_sxx_q    <= N2W'(s1_sx_q * s1_sx_q);
      s2_syy_q    <= N2W'(s1_sy_q * s1_sy_q);
      s2_pxx_q    <= PXW'(s1_ix_q * s1_sx_q);
      s2_pyy_q    <= PXW'(s1_iy_q * s1_sy_q);
      s2_p1_q     <= P1W'(angle_w_q * s1_conf_q);
      s2_inr_nz_q <= s1_inr_nz_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: intersection area, squared length and dot product
  // --------------------------------------------------------------------------
  logic [AREA_W-1:0]      s3_inter_q, s3_darea_q, s3_tarea_q;
  logic [N2W-1:0]         s3_n2_q;
  logic signed [DOTW-1:0] s3_dot_q;
  logic [P1W-1:0]         s3_p1_q;
  logic                   s3_disj_q, s3_inr_nz_q, s3_zero_uni_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_inter_q    <= AREA_W'(s2_dx_q * s2_dy_q);
      s3_darea_q    <= s2_darea_q;
      s3_tarea_q    <= s2_tarea_q;
      s3_n2_q       <= s2_sxx_q + s2_syy_q;
      s3_dot_q      <= DOTW'(s2_pxx_q) + DOTW'(s2_pyy_q);
      s3_p1_q       <= s2_p1_q;
      s3_disj_q     <= s2_disj_q;
      s3_inr_nz_q   <= s2_inr_nz_q;
      // An overlapping pair has an empty union only when both areas are empty.
      s3_zero_uni_q <= (s2_darea_q == '0) && (s2_tarea_q == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: union, radicand and dot magnitude; feeds the long pipelines
  // --------------------------------------------------------------------------
  logic [UNI_W-1:0]       s4_uni_q;
  logic [AREA_W+15:0]     s4_num_iou_q;
  logic [VW-1:0]          s4_rad_q;
  sb_t                    s4_sb_q;
  sb_t                    s4_sb_d;
  logic signed [DOTW-1:0] dot_abs;

  assign dot_abs = s3_dot_q[DOTW-1] ? -s3_dot_q : s3_dot_q;

  always_comb begin
    s4_sb_d          = '0;
    s4_sb_d.mag      = MW'(dot_abs);
    s4_sb_d.neg      = s3_dot_q[DOTW-1];
    s4_sb_d.dir_ok   = s3_inr_nz_q && (s3_n2_q != '0);
    s4_sb_d.p1       = s3_p1_q;
    s4_sb_d.disj     = s3_disj_q;
    s4_sb_d.zero_uni = s3_zero_uni_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_uni_q     <= UNI_W'(s3_tarea_q) + UNI_W'(s3_darea_q) - UNI_W'(s3_inter_q);
      s4_num_iou_q <= {s3_inter_q, 16'd0};
      s4_rad_q     <= {s3_n2_q, 16'd0};
      s4_sb_q      <= s4_sb_d;
    end
  end

  // --------------------------------------------------------------------------
  // IoU divider and direction length square root, side by side
  // --------------------------------------------------------------------------
  logic [IOU_QW-1:0] iou_quo;
  logic [RW-1:0]     norm_root;

  tdpc_div #(
    .NW (AREA_W + 16),
    .DW (UNI_W),
    .QW (IOU_QW)
  ) u_iou_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s4_num_iou_q),
    .den_i (s4_uni_q),
    .quo_o (iou_quo)
  );

  tdpc_isqrt #(
    .VW (VW)
  ) u_norm_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (s4_rad_q),
    .root_o (norm_root)
  );

  // Side data and IoU follow the square root.
  sb_t               sqrt_dly_q [RW];
  logic [IOU_W-1:0]  iou_dly_q  [IOU_DLY];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqrt_dly_q[0] <= s4_sb_q;
      for (int i = 1; i < RW; i++) begin
        sqrt_dly_q[i] <= sqrt_dly_q[i-1];
      end
      iou_dly_q[0] <= iou_quo;
      for (int i = 1; i < IOU_DLY; i++) begin
        iou_dly_q[i] <= iou_dly_q[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Cosine range check: a quotient of 2^15 or more saturates.
  // --------------------------------------------------------------------------
  logic [MW+7:0] cos_num_q;
  logic [RW-1:0] cos_den_q;
  sb_t           ov_sb_q;
  sb_t           ov_sb_d;
  logic [MW+7:0] cos_num_d;

  assign cos_num_d = {sqrt_dly_q[RW-1].mag, 8'd0};

  always_comb begin
    ov_sb_d     = sqrt_dly_q[RW-1];
    ov_sb_d.iou = iou_dly_q[IOU_DLY-1];
    ov_sb_d.ovf = CMPW'(cos_num_d) >= (CMPW'(norm_root) << COS_QW);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cos_num_q <= cos_num_d;
      cos_den_q <= norm_root;
      ov_sb_q   <= ov_sb_d;
    end
  end

  logic [COS_QW-1:0] cos_quo;

  tdpc_div #(
    .NW (MW + 8),
    .DW (RW),
    .QW (COS_QW)
  ) u_cos_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (cos_num_q),
    .den_i (cos_den_q),
    .quo_o (cos_quo)
  );

  sb_t cos_dly_q [COS_QW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      cos_dly_q[0] <= ov_sb_q;
      for (int i = 1; i < COS_QW; i++) begin
        cos_dly_q[i] <= cos_dly_q[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Table index from the clamped cosine magnitude
  // --------------------------------------------------------------------------
  logic [14:0]    cos_mag;
  logic [IPW-1:0] idx_prod;
  logic [IW-1:0]  idx_q;
  sb_t            idx_sb_q;

  always_comb begin
    if (cos_dly_q[COS_QW-1].ovf || (cos_quo > COS_ONE)) begin
      cos_mag = COS_ONE;
    end else begin
      cos_mag = cos_quo;
    end
    idx_prod = IPW'(cos_mag) * IPW'(ASIN_TABLE_DEPTH - 1) + IPW'(8192);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      idx_q    <= idx_prod[14 +: IW];
      idx_sb_q <= cos_dly_q[COS_QW-1];
    end
  end

  // --------------------------------------------------------------------------
  // Arcsine table, built at elaboration, registered read
  // --------------------------------------------------------------------------
  logic [ASIN_ENTRY_W-1:0] asin_rom [ASIN_TABLE_DEPTH];

  for (genvar k = 0; k < ASIN_TABLE_DEPTH; k++) begin : g_asin_rom
    localparam logic [ASIN_ENTRY_W-1:0] ENTRY = asin_entry(k, ASIN_TABLE_DEPTH);
    assign asin_rom[k] = ENTRY;
  end

  logic [ASIN_ENTRY_W-1:0] rom_q;
  sb_t                     rom_sb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rom_q    <= asin_rom[idx_q];
      rom_sb_q <= idx_sb_q;
    end
  end

  // --------------------------------------------------------------------------
  // Weight times confidence times table entry
  // --------------------------------------------------------------------------
  logic [PW-1:0] mul_q;
  sb_t           mul_sb_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mul_q    <= PW'(rom_sb_q.p1 * rom_q);
      mul_sb_q <= rom_sb_q;
    end
  end

  // --------------------------------------------------------------------------
  // Gating, rounding and the output register
  // --------------------------------------------------------------------------
  logic [PW:0]         term_sum;
  logic [17:0]         term_mag;
  logic signed [19:0]  term_s;
  logic signed [19:0]  score_sum;
  logic                gated_d;
  logic                empty_d;

  always_comb begin
    term_sum  = {1'b0, mul_q} + (PW+1)'(64'h8000_0000);
    term_mag  = term_sum[49:32];
    term_s    = 20'sd0;
    if (mul_sb_q.dir_ok) begin
      term_s = mul_sb_q.neg ? -signed'(20'(term_mag)) : signed'(20'(term_mag));
    end
    empty_d   = mul_sb_q.disj || mul_sb_q.zero_uni;
    gated_d   = empty_d || (mul_sb_q.iou < iou_thr_q);
    score_sum = signed'(20'(mul_sb_q.iou)) + term_s;
  end

  logic                 out_gated_q;
  logic [SCORE_W-1:0]   out_score_q;
  logic [IOU_W-1:0]     out_iou_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_gated_q <= gated_d;
      out_score_q <= gated_d ? '0 : score_sum[SCORE_W-1:0];
      out_iou_q   <= empty_d ? '0 : mul_sb_q.iou;
    end
  end

  assign m_axis_tvalid = vld_q[NSTAGE-1];
  assign m_axis_tuser  = out_gated_q;
  assign m_axis_tdata  = {(OUT_DATA_W-SCORE_W-IOU_W)'(0), out_iou_q, out_score_q};

endmodule

`default_nettype wire
